FILE: hdl/acbc_pkg.sv
// ----------------------------------------------------------------------------
// acbc_pkg: shared types, codes and AES helpers
// Payload structs, register indexes, sequencer states and the byte-level
// AES functions used by the round unit and the key expander.
// ----------------------------------------------------------------------------
package acbc_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RkDepth   = 11;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t RegKeyHigh  = 2'd0;
  localparam reg_index_t RegKeyLow   = 2'd1;
  localparam reg_index_t RegDirection = 2'd2;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;
    logic [3:0]  bytes_valid;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        out_last;
    logic [4:0]  out_bytes;
    logic        pad_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StKey,
    StRound,
    StDone,
    StOut
  } state_t;

  // round unit control
  typedef struct packed {
    logic       load;
    logic       decrypt;
    logic       last_round;
  } round_ctrl_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xt(p);
    end
    gmul = r;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte i of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] byte_of(input logic [127:0] b, input int i);
    byte_of = b[127 - 8 * i -: 8];
  endfunction

endpackage

FILE: hdl/acbc_ram.sv
// ----------------------------------------------------------------------------
// acbc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module acbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/acbc_key_expand.sv
// ----------------------------------------------------------------------------
// acbc_key_expand: one key schedule round per cycle
// Steps from round key r to round key r+1 on the given round constant.
// ----------------------------------------------------------------------------
module acbc_key_expand (
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  output logic [127:0] key_out
);

  logic [31:0] t;
  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] w2;
  logic [31:0] w3;

  // rot-word, sub-word, rcon then the word chain
  always_comb begin
    t = {acbc_pkg::SBOX[key_in[23:16]] ^ rcon, acbc_pkg::SBOX[key_in[15:8]],
         acbc_pkg::SBOX[key_in[7:0]], acbc_pkg::SBOX[key_in[31:24]]};
    w0 = key_in[127:96] ^ t;
    w1 = key_in[95:64] ^ w0;
    w2 = key_in[63:32] ^ w1;
    w3 = key_in[31:0] ^ w2;
    key_out = {w0, w1, w2, w3};
  end

endmodule

FILE: hdl/acbc_round.sv
// ----------------------------------------------------------------------------
// acbc_round: shared AES round unit
// One forward or inverse round per cycle on the state register.
// ----------------------------------------------------------------------------
module acbc_round (
  input  logic                  clk,
  input  acbc_pkg::round_ctrl_t ctrl,
  input  logic [127:0]          load_data,
  input  logic [127:0]          round_key,
  output logic [127:0]          state
);

  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   m [16];
  logic [127:0] res;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = acbc_pkg::byte_of(state, i);
    // substitute and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.decrypt) t[((c + r) % 4) * 4 + r] = acbc_pkg::INV_SBOX[s[c * 4 + r]];
        else t[c * 4 + r] = acbc_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
      end
    end
    // inverse order adds the key before mixing
    if (ctrl.decrypt) begin
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ acbc_pkg::byte_of(round_key, i);
    end
    // mix columns
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.decrypt)
          m[c*4+r] = acbc_pkg::gmul(t[c*4+r], 8'd14) ^ acbc_pkg::gmul(t[c*4+(r+1)%4], 8'd11)
                   ^ acbc_pkg::gmul(t[c*4+(r+2)%4], 8'd13) ^ acbc_pkg::gmul(t[c*4+(r+3)%4], 8'd9);
        else
          m[c*4+r] = acbc_pkg::xt(t[c*4+r]) ^ acbc_pkg::xt(t[c*4+(r+1)%4])
                   ^ t[c*4+(r+1)%4] ^ t[c*4+(r+2)%4] ^ t[c*4+(r+3)%4];
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctrl.last_round) res[127 - 8 * i -: 8] = t[i];
      else res[127 - 8 * i -: 8] = m[i];
    end
    if (!ctrl.decrypt) res = res ^ round_key;
  end

  // state register: initial key add on load
  always_ff @(posedge clk) begin
    if (ctrl.load) state <= load_data ^ round_key;
    else state <= res;
  end

endmodule

FILE: hdl/aes128_cbc_block_engine_core.sv
// ----------------------------------------------------------------------------
// aes128_cbc_block_engine_core: AES-128 CBC engine with 0x80 padding
// Sequencer around a shared round unit, a key expander and a round key RAM.
// ----------------------------------------------------------------------------
// After its transfer a block first loads the state with the initial key add
// (its round key is read in the transfer cycle), then runs the ten rounds of
// the shared round unit (one per cycle, key read from the round key RAM the
// cycle before) and finally registers the result. An encrypt IV block has its
// echo valid the cycle after its transfer; a decrypt IV block and a block
// outside a message give no result, and the next block can be taken the cycle
// after. A key register write keeps the input blocked while the idle state
// latches the key and the key state expands it into the RAM. After reset the
// same expansion of the zero key runs before the first block is taken. The
// result register holds until its transfer, and the next block is taken the
// cycle after that.
module aes128_cbc_block_engine_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  acbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acbc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  acbc_pkg::cfg_item_t cfg_data
);

  acbc_pkg::state_t state;
  acbc_pkg::state_t state_next;

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic         direction;
  logic [127:0] chain;
  logic         in_message;
  logic [127:0] blk;
  logic         blk_last;
  logic [3:0]   blk_bytes;
  logic         key_dirty;
  logic         key_wr;
  logic [3:0]   cnt;
  logic [127:0] kx;
  logic [7:0]   rcon;
  logic [7:0]   rcon_reg;
  logic [127:0] kx_next;
  logic [127:0] rk;
  logic [3:0]   raddr;
  logic         we;
  logic [127:0] round_state;
  logic [127:0] load_data;
  acbc_pkg::round_ctrl_t ctrl;
  logic [127:0] res;
  logic [7:0]   rb [16];
  logic [4:0]   nbytes;
  logic         perr;
  logic         found;
  logic [127:0] padded;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == acbc_pkg::StIdle) && !key_dirty && !out_valid;
  assign key_wr = cfg_valid && cfg_ready &&
                  (cfg_data.index == acbc_pkg::RegKeyHigh ||
                   cfg_data.index == acbc_pkg::RegKeyLow);

  acbc_key_expand u_kx (.key_in(kx), .rcon(rcon), .key_out(kx_next));

  acbc_ram #(.Width(128), .Depth(acbc_pkg::RkDepth)) u_rk (
    .clk(clk), .we(we), .waddr(cnt), .wdata(kx), .raddr(raddr), .rdata(rk)
  );

  acbc_round u_round (
    .clk(clk), .ctrl(ctrl), .load_data(load_data), .round_key(rk), .state(round_state)
  );

  // pad the plaintext, chain it (encrypt); a decrypt loads the block as it is
  always_comb begin
    padded = blk;
    if (blk_last) begin
      for (int i = 0; i < 16; i++) begin
        if (i == int'(blk_bytes)) padded[127 - 8 * i -: 8] = 8'h80;
        else if (i > int'(blk_bytes)) padded[127 - 8 * i -: 8] = 8'h00;
      end
    end
    load_data = padded ^ chain;
    if (direction) load_data = blk;
  end

  // sequencer next state and controls
  always_comb begin
    state_next = state;
    we = 1'b0;
    ctrl = '0;
    ctrl.decrypt = direction;
    raddr = direction ? 4'(acbc_pkg::NumRounds) : 4'd0;
    case (state)
      acbc_pkg::StIdle: begin
        if (key_dirty) state_next = acbc_pkg::StKey;
        else if (in_valid && in_ready && !in_data.first_block && in_message)
          state_next = acbc_pkg::StRound;
      end
      acbc_pkg::StKey: begin
        we = 1'b1;
        if (cnt == 4'(acbc_pkg::NumRounds)) state_next = acbc_pkg::StIdle;
      end
      acbc_pkg::StRound: begin
        // cnt 0 loads; round key for the next step is read now
        ctrl.load = (cnt == 4'd0);
        ctrl.last_round = (cnt == 4'(acbc_pkg::NumRounds));
        raddr = direction ? 4'(acbc_pkg::NumRounds - 1) - cnt : cnt + 4'd1;
        if (cnt == 4'(acbc_pkg::NumRounds)) state_next = acbc_pkg::StDone;
      end
      acbc_pkg::StDone: state_next = acbc_pkg::StIdle;
      default: state_next = acbc_pkg::StIdle;
    endcase
  end

  // block result (unchained when decrypting) and its unpadding
  always_comb begin
    res = direction ? (round_state ^ chain) : round_state;
    for (int i = 0; i < 16; i++) rb[i] = acbc_pkg::byte_of(res, i);
    found = 1'b0;
    perr = 1'b1;
    nbytes = 5'd0;
    for (int p = 15; p >= 0; p--) begin
      if (!found && rb[p] != 8'h00) begin
        found = 1'b1;
        if (rb[p] == 8'h80) begin
          perr = 1'b0;
          nbytes = 5'(p);
        end
      end
    end
  end

  assign rcon = (cnt == 4'd0) ? 8'h01 : acbc_pkg::xt(rcon_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acbc_pkg::StIdle;
      key_high <= '0;
      key_low <= '0;
      direction <= 1'b0;
      chain <= '0;
      in_message <= 1'b0;
      key_dirty <= 1'b1;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      // configuration
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          acbc_pkg::RegKeyHigh: key_high <= cfg_data.data;
          acbc_pkg::RegKeyLow: key_low <= cfg_data.data;
          acbc_pkg::RegDirection: direction <= cfg_data.data[0];
          default: ;
        endcase
      end
      // a key write always asks for a fresh expansion
      if (key_wr) key_dirty <= 1'b1;
      else if (state == acbc_pkg::StIdle && key_dirty) key_dirty <= 1'b0;
      case (state)
        acbc_pkg::StIdle: begin
          cnt <= '0;
          if (key_dirty) begin
            kx <= {key_high, key_low};
          end else if (in_valid && in_ready) begin
            blk <= {in_data.block_high, in_data.block_low};
            blk_last <= in_data.last_block;
            blk_bytes <= in_data.bytes_valid;
            if (in_data.first_block) begin
              chain <= {in_data.block_high, in_data.block_low};
              in_message <= 1'b1;
              if (!direction) begin
                out_valid <= 1'b1;
                out_data <= {in_data.block_high, in_data.block_low, 1'b0, 5'd16, 1'b0};
              end
            end
          end
        end
        acbc_pkg::StKey: begin
          kx <= kx_next;
          rcon_reg <= rcon;
          cnt <= cnt + 4'd1;
        end
        acbc_pkg::StRound: cnt <= cnt + 4'd1;
        acbc_pkg::StDone: begin
          out_valid <= 1'b1;
          out_data.out_high <= res[127:64];
          out_data.out_low <= res[63:0];
          out_data.out_last <= blk_last;
          out_data.out_bytes <= (direction && blk_last) ? nbytes : 5'd16;
          out_data.pad_error <= direction && blk_last && perr;
          chain <= direction ? blk : round_state;
          if (blk_last) in_message <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/acbc_checker.sv
// ----------------------------------------------------------------------------
// acbc_checker: port-level checks on the CBC engine
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module acbc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input acbc_pkg::out_item_t out_data
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new block taken while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("block taken over a waiting result");

  // byte count never above a full block
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_bytes <= 5'd16)
    else $error("byte count out of range");

  // pad error only on a last block with zero bytes
  a_perr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pad_error |-> out_data.out_last && out_data.out_bytes == 5'd0)
    else $error("pad error on a bad result");

endmodule

bind aes128_cbc_block_engine_core acbc_checker u_acbc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
